// ===== src/spq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  // fixed field widths of the ports
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned TASK_W   = 8;
  localparam int unsigned PRIO_W   = 8;
  localparam int unsigned OCC_W    = 5;

  // request codes carried in the mode field
  typedef enum logic [MODE_W-1:0] {
    MODE_ADD = 2'd0,
    MODE_DEL = 2'd1,
    MODE_POP = 2'd2,
    MODE_CLR = 2'd3
  } mode_e;

  // per-cycle command broadcast to every cell of the row
  typedef enum logic [2:0] {
    OP_HOLD = 3'd0,
    OP_INS  = 3'd1,
    OP_POP  = 3'd2,
    OP_DEL  = 3'd3,
    OP_CLR  = 3'd4
  } op_e;

  typedef struct packed {
    op_e op;
  } cell_cmd_t;

endpackage

`default_nettype wire

// ===== src/spq_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module spq_cell #(
  parameter int unsigned ID_BITS       = 8,
  parameter int unsigned PRIORITY_BITS = 8
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  spq_pkg::cell_cmd_t      cmd_i,
  input  wire [ID_BITS-1:0]       key_id_i,
  input  wire [PRIORITY_BITS-1:0] key_pri_i,
  // neighbor toward the head
  input  wire                     prev_valid_i,
  input  wire [ID_BITS-1:0]       prev_id_i,
  input  wire [PRIORITY_BITS-1:0] prev_pri_i,
  input  wire                     prev_ge_i,
  input  wire                     prev_hit_i,
  // neighbor toward the tail
  input  wire                     next_valid_i,
  input  wire [ID_BITS-1:0]       next_id_i,
  input  wire [PRIORITY_BITS-1:0] next_pri_i,
  output logic                    ge_o,
  output logic                    hit_o,
  output logic                    valid_o,
  output logic [ID_BITS-1:0]      id_o,
  output logic [PRIORITY_BITS-1:0] pri_o
);
  import spq_pkg::*;

  logic                     valid_q, valid_d;
  logic [ID_BITS-1:0]       id_q, id_d;
  logic [PRIORITY_BITS-1:0] pri_q, pri_d;
  logic                     load;

  // entry stays ahead of a new one of equal or lower priority
  assign ge_o  = valid_q && (pri_q >= key_pri_i);
  // first matching entry at or before this cell pulls the tail left
  assign hit_o = prev_hit_i || (valid_q && (id_q == key_id_i));

  always_comb begin
    valid_d = valid_q;
    id_d    = id_q;
    pri_d   = pri_q;
    load    = 1'b0;
    case (cmd_i.op)
      OP_INS: begin
        if (!ge_o) begin
          load = 1'b1;
          if (prev_ge_i) begin
            valid_d = 1'b1;
            id_d    = key_id_i;
            pri_d   = key_pri_i;
          end else begin
            valid_d = prev_valid_i;
            id_d    = prev_id_i;
            pri_d   = prev_pri_i;
          end
        end
      end
      OP_POP: begin
        load    = 1'b1;
        valid_d = next_valid_i;
        id_d    = next_id_i;
        pri_d   = next_pri_i;
      end
      OP_DEL: begin
        if (hit_o) begin
          load    = 1'b1;
          valid_d = next_valid_i;
          id_d    = next_id_i;
          pri_d   = next_pri_i;
        end
      end
      OP_CLR: begin
        valid_d = 1'b0;
      end
      default: begin
        valid_d = valid_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      id_q  <= id_d;
      pri_q <= pri_d;
    end
  end

  assign valid_o = valid_q;
  assign id_o    = id_q;
  assign pri_o   = pri_q;

endmodule

`default_nettype wire

// ===== src/sorted_priority_task_queue.sv =====
// add, pop and clear give their result beat in the cycle after the input beat
// delete removes one matching entry per cycle, and gives its result once none is left and the output is free
// throughput: one beat per cycle for add, pop and clear while the output is taken
// rate is set by the cell row shifting one slot per cycle
// reset: queue empty, dispatch enabled, no result pending
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_task_queue #(
  parameter int unsigned QUEUE_DEPTH   = 16,
  parameter int unsigned ID_BITS       = 8,
  parameter int unsigned PRIORITY_BITS = 8
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  // configuration: dispatch enable
  input  wire                         cfg_we_i,
  input  wire                         cfg_wdata_i,
  // request channel
  input  wire                         in_valid_i,
  output logic                        in_ready_o,
  input  wire [spq_pkg::MODE_W-1:0]   mode_i,
  input  wire [spq_pkg::TASK_W-1:0]   task_id_i,
  input  wire [spq_pkg::PRIO_W-1:0]   priority_req_i,
  // result channel
  output logic                        out_valid_o,
  input  wire                         out_ready_i,
  output logic                        accepted_o,
  output logic                        task_valid_o,
  output logic [spq_pkg::TASK_W-1:0]  task_out_o,
  output logic [spq_pkg::OCC_W-1:0]   occupancy_o
);
  import spq_pkg::*;

  localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned IDX_W  = (ID_BITS > TASK_W) ? ID_BITS : TASK_W;
  localparam int unsigned PRX_W  = (PRIORITY_BITS > PRIO_W) ? PRIORITY_BITS : PRIO_W;
  localparam int unsigned OCX_W  = (CNT_W > OCC_W) ? CNT_W : OCC_W;

  // controller states, one-hot
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DEL  = 2'b10
  } state_e;

  state_e             state_q, state_d;
  logic [ID_BITS-1:0] del_id_q;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               dispatch_q;

  logic               out_valid_q, out_valid_d;
  logic               accepted_q;
  logic               task_valid_q;
  logic [TASK_W-1:0]  task_out_q;
  logic [OCC_W-1:0]   occupancy_q;

  // result load
  logic               res_load;
  logic               res_accepted;
  logic               res_task_valid;
  logic [TASK_W-1:0]  res_task_out;
  logic [CNT_W-1:0]   res_count;

  logic               in_accept;
  logic               out_free;
  logic               full;
  logic               pop_go;
  logic               any_hit;
  cell_cmd_t          cmd;

  // request fields brought to the cell widths
  logic [IDX_W-1:0]         in_id_ext;
  logic [PRX_W-1:0]         in_pri_ext;
  logic [ID_BITS-1:0]       key_id;
  logic [PRIORITY_BITS-1:0] key_pri;
  logic [IDX_W-1:0]         head_id_ext;
  logic [OCX_W-1:0]         occ_ext;

  // the cell row, head at index 0
  logic [QUEUE_DEPTH-1:0]   cell_valid;
  logic [QUEUE_DEPTH-1:0]   cell_ge;
  logic [QUEUE_DEPTH-1:0]   cell_hit;
  logic [ID_BITS-1:0]       cell_id  [QUEUE_DEPTH];
  logic [PRIORITY_BITS-1:0] cell_pri [QUEUE_DEPTH];

  assign in_id_ext  = IDX_W'(task_id_i);
  assign in_pri_ext = PRX_W'(priority_req_i);
  // in delete state the stored id keeps driving the match chain
  assign key_id     = state_q[1] ? del_id_q : in_id_ext[ID_BITS-1:0];
  assign key_pri    = in_pri_ext[PRIORITY_BITS-1:0];

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign in_accept  = in_valid_i && in_ready_o;
  assign full       = cell_valid[QUEUE_DEPTH-1];
  assign pop_go     = dispatch_q && cell_valid[0];
  assign any_hit    = cell_hit[QUEUE_DEPTH-1];

  // command for the row this cycle
  always_comb begin
    cmd.op = OP_HOLD;
    if (in_accept) begin
      unique case (mode_e'(mode_i))
        MODE_ADD: cmd.op = full ? OP_HOLD : OP_INS;
        MODE_DEL: cmd.op = OP_DEL;
        MODE_POP: cmd.op = pop_go ? OP_POP : OP_HOLD;
        MODE_CLR: cmd.op = OP_CLR;
        default:  cmd.op = OP_HOLD;
      endcase
    end else if (state_q == ST_DEL) begin
      cmd.op = OP_DEL;
    end
  end

  // occupancy follows the row command
  always_comb begin
    count_d = count_q;
    case (cmd.op)
      OP_INS:  count_d = count_q + 1'b1;
      OP_POP:  count_d = count_q - 1'b1;
      OP_DEL:  count_d = any_hit ? (count_q - 1'b1) : count_q;
      OP_CLR:  count_d = '0;
      default: count_d = count_q;
    endcase
  end

  assign head_id_ext = IDX_W'(cell_id[0]);

  // sequencing and result capture
  always_comb begin
    state_d        = state_q;
    res_load       = 1'b0;
    res_accepted   = 1'b1;
    res_task_valid = 1'b0;
    res_task_out   = '0;
    res_count      = count_d;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (mode_e'(mode_i) == MODE_DEL) begin
            if (any_hit) begin
              state_d = ST_DEL;
            end else begin
              res_load = 1'b1;
            end
          end else begin
            res_load       = 1'b1;
            res_accepted   = !((mode_e'(mode_i) == MODE_ADD) && full);
            res_task_valid = (mode_e'(mode_i) == MODE_POP) && pop_go;
            res_task_out   = res_task_valid ? head_id_ext[TASK_W-1:0] : '0;
          end
        end
      end
      ST_DEL: begin
        // one match removed per cycle until none is left
        if (!any_hit && out_free) begin
          res_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = res_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  assign occ_ext     = OCX_W'(res_count);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      dispatch_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        dispatch_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      del_id_q <= in_id_ext[ID_BITS-1:0];
    end
    if (res_load) begin
      accepted_q   <= res_accepted;
      task_valid_q <= res_task_valid;
      task_out_q   <= res_task_out;
      occupancy_q  <= occ_ext[OCC_W-1:0];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign accepted_o   = accepted_q;
  assign task_valid_o = task_valid_q;
  assign task_out_o   = task_out_q;
  assign occupancy_o  = occupancy_q;

  // row of cells, each linked to its neighbors, with the head and tail ends tied off
  for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
    logic                     p_valid, n_valid, p_ge, p_hit;
    logic [ID_BITS-1:0]       p_id, n_id;
    logic [PRIORITY_BITS-1:0] p_pri, n_pri;

    if (k == 0) begin : g_head
      assign p_valid = 1'b0;
      assign p_id    = '0;
      assign p_pri   = '0;
      assign p_ge    = 1'b1;
      assign p_hit   = 1'b0;
    end else begin : g_link
      assign p_valid = cell_valid[k-1];
      assign p_id    = cell_id[k-1];
      assign p_pri   = cell_pri[k-1];
      assign p_ge    = cell_ge[k-1];
      assign p_hit   = cell_hit[k-1];
    end

    if (k == QUEUE_DEPTH - 1) begin : g_tail
      assign n_valid = 1'b0;
      assign n_id    = '0;
      assign n_pri   = '0;
    end else begin : g_next
      assign n_valid = cell_valid[k+1];
      assign n_id    = cell_id[k+1];
      assign n_pri   = cell_pri[k+1];
    end

    spq_cell #(
      .ID_BITS       (ID_BITS),
      .PRIORITY_BITS (PRIORITY_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .key_id_i     (key_id),
      .key_pri_i    (key_pri),
      .prev_valid_i (p_valid),
      .prev_id_i    (p_id),
      .prev_pri_i   (p_pri),
      .prev_ge_i    (p_ge),
      .prev_hit_i   (p_hit),
      .next_valid_i (n_valid),
      .next_id_i    (n_id),
      .next_pri_i   (n_pri),
      .ge_o         (cell_ge[k]),
      .hit_o        (cell_hit[k]),
      .valid_o      (cell_valid[k]),
      .id_o         (cell_id[k]),
      .pri_o        (cell_pri[k])
    );
  end

`ifndef SYNTHESIS
  // held entries always sit packed at the head
  a_valid_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cell_valid & (cell_valid + 1'b1)) == '0))
    else $error("valid entries not packed at the head");

  // the counter tracks the number of held entries
  a_count_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(count_q) == 32'($countones(cell_valid))))
    else $error("occupancy counter out of step with the cell row");

  // a clear beat empties the row
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (mode_i == MODE_CLR)) |=> (cell_valid == '0))
    else $error("clear left entries behind");

  // a popped task always comes with an accepted result
  a_pop_accepted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && task_valid_o) |-> accepted_o)
    else $error("popped task on a refused result");
`endif

endmodule

`default_nettype wire
